// ----- hdl/fvsg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvsg_pkg: shared definitions for the file view segment generator
// Sizes, register codes, opcodes and the bundles passed between submodules.
// ----------------------------------------------------------------------------
package fvsg_pkg;

  localparam int MAX_SEGMENTS = 256;
  localparam int MAX_PIECES   = 64;

  localparam int SEG_IDX_W   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SEG_CNT_W   = $clog2(MAX_SEGMENTS + 1);
  localparam int SKIP_W      = SEG_CNT_W + 1;
  localparam int PIECE_CNT_W = $clog2(MAX_PIECES + 1);

  localparam int ADDR_W     = 48;
  localparam int LEN_W      = 32;
  localparam int INDEX_W    = 8;
  localparam int CNT_REG_W  = 9;
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 5;

  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  typedef enum logic [1:0] {
    REG_SEGMENT_COUNT     = 2'd0,
    REG_VIEW_EXTENT       = 2'd1,
    REG_VIEW_DISPLACEMENT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [CNT_REG_W-1:0] segment_count;
    logic [ADDR_W-1:0]    view_extent;
    logic [ADDR_W-1:0]    view_displacement;
  } cfg_t;

  typedef struct packed {
    logic                 we;
    logic [SEG_IDX_W-1:0] waddr;
    logic [ADDR_W-1:0]    base;
    logic [LEN_W-1:0]     len;
  } seg_wr_t;

  // Count of zero behaves as one; counts past the table size saturate.
  function automatic logic [SEG_CNT_W-1:0] eff_count(input logic [CNT_REG_W-1:0] c);
    logic [SEG_CNT_W-1:0] res;
    if (c == '0) begin
      res = SEG_CNT_W'(1);
    end else if (32'(c) > 32'(MAX_SEGMENTS)) begin
      res = SEG_CNT_W'(MAX_SEGMENTS);
    end else begin
      res = SEG_CNT_W'(c);
    end
    return res;
  endfunction

endpackage

// ----- hdl/fvsg_cfg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvsg_cfg: configuration register file
// APB-style slave holding segment count, view extent and view displacement.
// ----------------------------------------------------------------------------
module fvsg_cfg
  import fvsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  // Registers sit on 8-byte boundaries.
  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_SEGMENT_COUNT:     cfg_nxt.segment_count     = pwdata[CNT_REG_W-1:0];
        REG_VIEW_EXTENT:       cfg_nxt.view_extent       = pwdata[ADDR_W-1:0];
        REG_VIEW_DISPLACEMENT: cfg_nxt.view_displacement = pwdata[ADDR_W-1:0];
        default:               cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SEGMENT_COUNT:     prdata = APB_DATA_W'(cfg_r.segment_count);
      REG_VIEW_EXTENT:       prdata = APB_DATA_W'(cfg_r.view_extent);
      REG_VIEW_DISPLACEMENT: prdata = APB_DATA_W'(cfg_r.view_displacement);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.segment_count     <= CNT_REG_W'(1);
      cfg_r.view_extent       <= '0;
      cfg_r.view_displacement <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// ----- hdl/fvsg_seg_mem.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvsg_seg_mem: segment pattern memory
// One write port and one registered read port; each entry is base and length.
// ----------------------------------------------------------------------------
module fvsg_seg_mem
  import fvsg_pkg::*;
(
  input  logic                 clk,
  input  seg_wr_t              wr,
  input  logic [SEG_IDX_W-1:0] raddr,
  output logic [ADDR_W-1:0]    rd_base,
  output logic [LEN_W-1:0]     rd_len
);

  logic [ADDR_W+LEN_W-1:0] mem_r [MAX_SEGMENTS];
  logic [ADDR_W+LEN_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr.waddr] <= {wr.base, wr.len};
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem_r[raddr];
  end

  assign rd_base = rd_data_r[ADDR_W+LEN_W-1:LEN_W];
  assign rd_len  = rd_data_r[LEN_W-1:0];

endmodule

// ----- hdl/fvsg_walker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fvsg_walker: pattern walk sequencer
// Accepts loads and requests, keeps the view cursor and emits pieces. One
// piece is held back so the final one can be marked once the walk ends.
// ----------------------------------------------------------------------------
module fvsg_walker
  import fvsg_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  logic                 in_op,
  input  logic [INDEX_W-1:0]   in_entry_index,
  input  logic [ADDR_W-1:0]    in_entry_base,
  input  logic [LEN_W-1:0]     in_entry_length,
  input  logic [LEN_W-1:0]     in_request_bytes,
  input  cfg_t                 cfg,
  output seg_wr_t              mem_wr,
  output logic [SEG_IDX_W-1:0] mem_raddr,
  input  logic [ADDR_W-1:0]    mem_rd_base,
  input  logic [LEN_W-1:0]     mem_rd_len,
  output logic                 out_strobe,
  output logic [ADDR_W-1:0]    out_piece_address,
  output logic [LEN_W-1:0]     out_piece_length,
  output logic                 out_last_piece,
  output logic                 out_bytes_pending
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_EVAL = 5'b00100,
    ST_EMIT = 5'b01000,
    ST_DONE = 5'b10000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [SEG_IDX_W-1:0]   cur_r, cur_nxt;
  logic [ADDR_W-1:0]      off_r, off_nxt;
  logic [ADDR_W-1:0]      origin_r, origin_nxt;
  logic [ADDR_W-1:0]      od_r, od_nxt;
  logic [LEN_W-1:0]       rem_r, rem_nxt;
  logic [SKIP_W-1:0]      skips_r, skips_nxt;
  logic [PIECE_CNT_W-1:0] k_r, k_nxt;
  logic [LEN_W-1:0]       rest_r, rest_nxt;
  logic [ADDR_W-1:0]      part_r, part_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  logic [ADDR_W-1:0]      pend_addr_r, pend_addr_nxt;
  logic [LEN_W-1:0]       pend_len_r, pend_len_nxt;
  logic                   out_strobe_r, out_strobe_nxt;
  logic [ADDR_W-1:0]      out_addr_r, out_addr_nxt;
  logic [LEN_W-1:0]       out_len_r, out_len_nxt;
  logic                   out_last_r, out_last_nxt;
  logic                   out_pend_r, out_pend_nxt;

  logic [SEG_CNT_W-1:0]   count;
  logic [SEG_CNT_W-1:0]   cur_inc;
  logic [SKIP_W-1:0]      skips_inc;
  logic [LEN_W-1:0]       take;
  logic                   covers_rest;
  logic                   accept;

  assign count     = eff_count(cfg.segment_count);
  assign cur_inc   = SEG_CNT_W'(cur_r) + SEG_CNT_W'(1);
  assign skips_inc = skips_r + SKIP_W'(1);
  // The rest of the segment covers the request exactly when remaining <= rest.
  assign covers_rest = !(rest_r < rem_r);
  assign take        = covers_rest ? rem_r : rest_r;

  assign busy      = (state_r != ST_IDLE);
  assign accept    = start && !busy;
  assign mem_raddr = cur_r;

  always_comb begin
    mem_wr.we    = accept && (in_op == OP_LOAD) &&
                   (32'(in_entry_index) < 32'(MAX_SEGMENTS));
    mem_wr.waddr = SEG_IDX_W'(in_entry_index);
    mem_wr.base  = in_entry_base;
    mem_wr.len   = in_entry_length;
  end

  always_comb begin
    state_nxt      = state_r;
    cur_nxt        = cur_r;
    off_nxt        = off_r;
    origin_nxt     = origin_r;
    od_nxt         = od_r;
    rem_nxt        = rem_r;
    skips_nxt      = skips_r;
    k_nxt          = k_r;
    rest_nxt       = rest_r;
    part_nxt       = part_r;
    pend_valid_nxt = pend_valid_r;
    pend_addr_nxt  = pend_addr_r;
    pend_len_nxt   = pend_len_r;
    out_strobe_nxt = 1'b0;
    out_addr_nxt   = out_addr_r;
    out_len_nxt    = out_len_r;
    out_last_nxt   = out_last_r;
    out_pend_nxt   = out_pend_r;

    case (state_r)
      ST_IDLE: begin
        if (accept && (in_op == OP_REQUEST) && (in_request_bytes != '0)) begin
          rem_nxt        = in_request_bytes;
          skips_nxt      = '0;
          k_nxt          = '0;
          pend_valid_nxt = 1'b0;
          // A cursor left past a shrunken pattern restarts at the next lap.
          if (SEG_CNT_W'(cur_r) >= count) begin
            cur_nxt    = '0;
            off_nxt    = '0;
            origin_nxt = origin_r + cfg.view_extent;
          end
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        od_nxt    = cfg.view_displacement + origin_r;
        state_nxt = ST_EVAL;
      end
      ST_EVAL: begin
        if (off_r >= ADDR_W'(mem_rd_len)) begin
          off_nxt   = off_r - ADDR_W'(mem_rd_len);
          skips_nxt = skips_inc;
          if (cur_inc >= count) begin
            cur_nxt    = '0;
            off_nxt    = '0;
            origin_nxt = origin_r + cfg.view_extent;
          end else begin
            cur_nxt = SEG_IDX_W'(cur_inc);
          end
          // More than a full lap without data means every segment is empty.
          if (skips_inc > SKIP_W'(count)) begin
            state_nxt = ST_DONE;
          end else begin
            state_nxt = ST_READ;
          end
        end else begin
          skips_nxt = '0;
          rest_nxt  = mem_rd_len - off_r[LEN_W-1:0];
          part_nxt  = mem_rd_base + off_r;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (pend_valid_r) begin
          out_strobe_nxt = 1'b1;
          out_addr_nxt   = pend_addr_r;
          out_len_nxt    = pend_len_r;
          out_last_nxt   = 1'b0;
          out_pend_nxt   = 1'b0;
        end
        pend_valid_nxt = 1'b1;
        pend_addr_nxt  = od_r + part_r;
        pend_len_nxt   = take;
        off_nxt        = off_r + ADDR_W'(take);
        rem_nxt        = rem_r - take;
        k_nxt          = k_r + PIECE_CNT_W'(1);
        if (covers_rest || (k_nxt == PIECE_CNT_W'(MAX_PIECES))) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = ST_READ;
        end
      end
      ST_DONE: begin
        if (pend_valid_r) begin
          out_strobe_nxt = 1'b1;
          out_addr_nxt   = pend_addr_r;
          out_len_nxt    = pend_len_r;
          out_last_nxt   = 1'b1;
          out_pend_nxt   = (rem_r != '0);
        end
        pend_valid_nxt = 1'b0;
        state_nxt      = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      cur_r        <= '0;
      off_r        <= '0;
      origin_r     <= '0;
      skips_r      <= '0;
      k_r          <= '0;
      pend_valid_r <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_r        <= cur_nxt;
      off_r        <= off_nxt;
      origin_r     <= origin_nxt;
      skips_r      <= skips_nxt;
      k_r          <= k_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r        <= od_nxt;
    rem_r       <= rem_nxt;
    rest_r      <= rest_nxt;
    part_r      <= part_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_len_r  <= pend_len_nxt;
    out_addr_r  <= out_addr_nxt;
    out_len_r   <= out_len_nxt;
    out_last_r  <= out_last_nxt;
    out_pend_r  <= out_pend_nxt;
  end

  assign out_strobe        = out_strobe_r;
  assign out_piece_address = out_addr_r;
  assign out_piece_length  = out_len_r;
  assign out_last_piece    = out_last_r;
  assign out_bytes_pending = out_pend_r;

endmodule

// ----- hdl/file_view_segment_generator.sv -----
`timescale 1ns / 1ps
// A load leaves busy low; the next item may follow at once.
// A request steps through the read, evaluate and emit states for each piece, and read and evaluate per segment skipped.
// The rate is set by the segment memory read, evaluate and emit loop.
// A piece leaves once the next one is found; the final one in the cycle in which busy falls.
// Synchronous active-low reset clears the cursor, view origin, walker state and config registers;
// the segment memory is not cleared and results cannot be stalled.
// ----------------------------------------------------------------------------
// file_view_segment_generator: scatter-gather pieces for a repeating view
// Holds a segment pattern in memory and splits each request into pieces.
// ----------------------------------------------------------------------------
module file_view_segment_generator
  import fvsg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic                  in_op,
  input  logic [INDEX_W-1:0]    in_entry_index,
  input  logic [ADDR_W-1:0]     in_entry_base,
  input  logic [LEN_W-1:0]      in_entry_length,
  input  logic [LEN_W-1:0]      in_request_bytes,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic                  out_strobe,
  output logic [ADDR_W-1:0]     out_piece_address,
  output logic [LEN_W-1:0]      out_piece_length,
  output logic                  out_last_piece,
  output logic                  out_bytes_pending
);

  cfg_t                 cfg;
  seg_wr_t              mem_wr;
  logic [SEG_IDX_W-1:0] mem_raddr;
  logic [ADDR_W-1:0]    mem_rd_base;
  logic [LEN_W-1:0]     mem_rd_len;

  fvsg_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  fvsg_seg_mem u_seg_mem (
    .clk     (clk),
    .wr      (mem_wr),
    .raddr   (mem_raddr),
    .rd_base (mem_rd_base),
    .rd_len  (mem_rd_len)
  );

  fvsg_walker u_walker (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_op             (in_op),
    .in_entry_index    (in_entry_index),
    .in_entry_base     (in_entry_base),
    .in_entry_length   (in_entry_length),
    .in_request_bytes  (in_request_bytes),
    .cfg               (cfg),
    .mem_wr            (mem_wr),
    .mem_raddr         (mem_raddr),
    .mem_rd_base       (mem_rd_base),
    .mem_rd_len        (mem_rd_len),
    .out_strobe        (out_strobe),
    .out_piece_address (out_piece_address),
    .out_piece_length  (out_piece_length),
    .out_last_piece    (out_last_piece),
    .out_bytes_pending (out_bytes_pending)
  );

`ifndef SYNTHESIS
  // A beat is only produced while a request is in flight.
  a_strobe_from_request: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result beat without a request in flight");

  a_nonzero_piece: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_piece_length != '0))
    else $error("zero-length piece emitted");

  a_pending_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_bytes_pending) |-> out_last_piece)
    else $error("bytes pending flagged on a piece that is not final");

  a_load_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_op == OP_LOAD)) |=> !busy)
    else $error("segment load left the block busy");
`endif

endmodule
